// ----- rtl/tmdr_pkg.sv -----
`default_nettype none
package tmdr_pkg;

  localparam int unsigned MAX_W    = 1024;
  localparam int unsigned MAX_H    = 1024;
  localparam int unsigned SUB_BITS = 4;
  localparam int unsigned XW       = $clog2(MAX_W + 1);
  localparam int unsigned YW       = $clog2(MAX_H + 1);
  localparam int unsigned STORE_N  = MAX_W * MAX_H;
  localparam int unsigned AW       = $clog2(STORE_N);

  // depth divider: numerator 2N+d, denominator 2d, quotient clamped to 2^QLIM_EXP
  localparam int unsigned NUM_W    = 80;
  localparam int unsigned DEN_W    = 41;
  localparam int unsigned Q_W      = 42;
  localparam int unsigned QLIM_EXP = 40;

endpackage
`default_nettype wire

// ----- rtl/tmdr_div.sv -----
`default_nettype none
module tmdr_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [tmdr_pkg::NUM_W-1:0]  num_i,
  input  logic        [tmdr_pkg::DEN_W-1:0]  den_i,
  output logic                               done_o,
  output logic signed [tmdr_pkg::Q_W-1:0]    quot_o
);
  import tmdr_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_e;

  localparam int unsigned HI_W = NUM_W - Q_W;
  localparam int unsigned CW   = $clog2(Q_W + 1);

  dstate_e            state_q;
  logic [CW-1:0]      cnt_q;
  logic [DEN_W-1:0]   rem_q;
  logic [Q_W-1:0]     low_q;
  logic [Q_W-1:0]     q_q;
  logic               neg_q;
  logic               sat_q;
  logic               done_q;
  logic signed [Q_W-1:0] quot_q;

  logic [NUM_W-1:0]   mag;
  logic [HI_W-1:0]    hi;
  logic               sat_c;
  logic [DEN_W:0]     rem2;
  logic [DEN_W:0]     diff;
  logic               ge;
  logic [Q_W:0]       qa;
  logic [Q_W:0]       qc;

  always_comb begin
    mag   = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    hi    = mag[NUM_W-1:Q_W];
    sat_c = {{DEN_W{1'b0}}, hi} >= {{HI_W{1'b0}}, den_i};
    rem2  = {rem_q, low_q[Q_W-1]};
    diff  = rem2 - {1'b0, den_i};
    ge    = rem2 >= {1'b0, den_i};
    qa    = {1'b0, q_q} + (Q_W+1)'(neg_q && (rem_q != '0));
    qc    = (sat_q || qa > ((Q_W+1)'(1) << QLIM_EXP)) ? ((Q_W+1)'(1) << QLIM_EXP) : qa;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            state_q <= D_RUN;
            cnt_q   <= CW'(Q_W);
          end
        end
        D_RUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) state_q <= D_FIN;
        end
        D_FIN: begin
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      neg_q <= num_i[NUM_W-1];
      sat_q <= sat_c;
      rem_q <= DEN_W'(hi);
      low_q <= mag[Q_W-1:0];
      q_q   <= '0;
    end else if (state_q == D_RUN) begin
      rem_q <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      q_q   <= {q_q[Q_W-2:0], ge};
      low_q <= {low_q[Q_W-2:0], 1'b0};
    end
    if (state_q == D_FIN) begin
      quot_q <= neg_q ? Q_W'(-qc) : Q_W'(qc);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ----- rtl/triangle_minmax_depth_raster_core.sv -----
// Draw: a setup sequence, then a walk over every box pixel; each covered pixel also waits on
// the bit-serial depth divider (one quotient bit per cycle), which dominates the draw time.
// Clear: one store entry per cycle over all 1048576 entries. Read: registered store read, then output.
// One request at a time; result strobes on done_o for one cycle, receiver cannot stall.
// Reset sets the config registers to their defaults; depth stores are undefined until cleared.
`default_nettype none
module triangle_minmax_depth_raster_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic signed [18:0] v0_x_i,
  input  logic signed [18:0] v0_y_i,
  input  logic signed [31:0] v0_z_i,
  input  logic signed [18:0] v1_x_i,
  input  logic signed [18:0] v1_y_i,
  input  logic signed [31:0] v1_z_i,
  input  logic signed [18:0] v2_x_i,
  input  logic signed [18:0] v2_y_i,
  input  logic signed [31:0] v2_z_i,
  input  logic [19:0]        pixel_addr_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [20:0]        covered_pixels_o,
  output logic signed [31:0] read_min_o,
  output logic signed [31:0] read_max_o
);
  import tmdr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SETA, S_SWAP, S_PREP, S_SETB, S_LOAD, S_PIX, S_DIV, S_DEP, S_WB,
    S_CLEAR, S_RD, S_RDOUT
  } state_e;

  typedef enum logic [1:0] {A_DRAW, A_CLEAR, A_READ, A_NONE} action_e;
  typedef enum logic [1:0] {ST_DRAWN, ST_CULLED, ST_CLIPPED, ST_DONE} status_e;
  typedef enum logic [1:0] {R_WIDTH, R_HEIGHT, R_MINCLR, R_MAXCLR} reg_e;
  typedef enum logic [2:0] {T_NZ, T_NX, T_NY, T_E, T_N, T_ROW} tgt_e;

  typedef struct packed {
    tgt_e       tgt;
    logic [1:0] ei;
    logic       neg;
    logic       shl;
  } op_t;

  localparam logic [4:0] LAST_A  = 5'd6;
  localparam logic [4:0] FIRST_B = 5'd6;
  localparam logic [4:0] LAST_B  = 5'd23;
  localparam int unsigned SHL = 26;

  // control
  state_e          state_q;
  logic [4:0]      step_q;
  logic            opv_q;
  logic [AW-1:0]   clr_q;
  logic            done_q;
  status_e         status_q;
  logic [20:0]     cov_q;
  logic [31:0]     rmin_q, rmax_q;
  logic [10:0]     width_q, height_q;
  logic [31:0]     minclr_q, maxclr_q;

  // datapath
  op_t                   op_q;
  logic signed [54:0]    prod_q;
  logic signed [18:0]    vx_q [3];
  logic signed [18:0]    vy_q [3];
  logic signed [31:0]    z0_q, z1_q, z2_q;
  logic [19:0]           addr_q;
  logic signed [39:0]    nz_q;
  logic signed [53:0]    nx_q, ny_q;
  logic signed [41:0]    erow_q [3];
  logic signed [41:0]    e_q [3];
  logic signed [NUM_W-1:0] nrow_q, n_q;
  logic [AW-1:0]         rowbase_q;
  logic [XW-1:0]         px_q, xs_q, xe_q;
  logic [YW-1:0]         py_q, ye_q;
  logic [20:0]           cnt_q;
  logic signed [Q_W-1:0] qd_q;
  logic signed [31:0]    depth_q;
  logic signed [31:0]    min_rd_q, max_rd_q;

  logic [31:0] min_mem [STORE_N];
  logic [31:0] max_mem [STORE_N];

  logic               accept;
  logic signed [19:0] ex1, ey1, ex2, ey2;
  logic signed [32:0] ez1, ez2;
  logic signed [19:0] dx [3];
  logic signed [19:0] dy [3];
  logic [2:0]         tl;
  logic [XW-1:0]      w_c;
  logic [YW-1:0]      h_c;
  logic signed [18:0] minx, maxx, miny, maxy;
  logic signed [19:0] xs_r, xe_r, ys_r, ye_r, w_s, h_s, xs_c, xe_c, ys_c, ye_c;
  logic               empty;
  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  op_t                op_c;
  logic [4:0]         es;
  logic signed [20:0] bx, by;
  logic signed [NUM_W-1:0] pw;
  logic               covered, adv_x, adv_y, last, do_adv;
  logic [AW-1:0]      idx;
  logic signed [39:0] d_c;
  logic signed [NUM_W-1:0] num_c;
  logic [DEN_W-1:0]   den_c;
  logic               div_done;
  logic signed [Q_W-1:0] div_q;
  logic signed [42:0] dsum;
  logic signed [31:0] dsat;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [31:0]        min_wd, max_wd;
  logic [20:0]        cnt_nx;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    ex1 = 20'(vx_q[1]) - 20'(vx_q[0]);
    ey1 = 20'(vy_q[1]) - 20'(vy_q[0]);
    ex2 = 20'(vx_q[2]) - 20'(vx_q[0]);
    ey2 = 20'(vy_q[2]) - 20'(vy_q[0]);
    ez1 = 33'(z1_q) - 33'(z0_q);
    ez2 = 33'(z2_q) - 33'(z0_q);
    for (int i = 0; i < 3; i++) begin
      dx[i] = 20'(vx_q[i]) - 20'(vx_q[(i == 2) ? 0 : i + 1]);
      dy[i] = 20'(vy_q[i]) - 20'(vy_q[(i == 2) ? 0 : i + 1]);
      tl[i] = (dy[i] < 0) || (dy[i] == 0 && dx[i] > 0);
    end
  end

  // active size and clipped bounding box
  always_comb begin
    w_c  = ({21'd0, width_q} > 32'(MAX_W)) ? XW'(MAX_W) : XW'(width_q);
    h_c  = ({21'd0, height_q} > 32'(MAX_H)) ? YW'(MAX_H) : YW'(height_q);
    minx = vx_q[0];
    maxx = vx_q[0];
    miny = vy_q[0];
    maxy = vy_q[0];
    for (int i = 1; i < 3; i++) begin
      if (vx_q[i] < minx) minx = vx_q[i];
      if (vx_q[i] > maxx) maxx = vx_q[i];
      if (vy_q[i] < miny) miny = vy_q[i];
      if (vy_q[i] > maxy) maxy = vy_q[i];
    end
    xs_r  = (20'(minx) + 20'sd15) >>> SUB_BITS;
    xe_r  = (20'(maxx) + 20'sd15) >>> SUB_BITS;
    ys_r  = (20'(miny) + 20'sd15) >>> SUB_BITS;
    ye_r  = (20'(maxy) + 20'sd15) >>> SUB_BITS;
    w_s   = 20'(w_c);
    h_s   = 20'(h_c);
    xs_c  = (xs_r < 0) ? '0 : xs_r;
    ys_c  = (ys_r < 0) ? '0 : ys_r;
    xe_c  = (xe_r > w_s) ? w_s : xe_r;
    ye_c  = (ye_r > h_s) ? h_s : ye_r;
    empty = (xs_c >= xe_c) || (ys_c >= ye_c);
  end

  // setup sequence: one product per step
  always_comb begin
    bx    = (21'(xs_q) <<< SUB_BITS) - 21'(vx_q[0]);
    by    = (21'(ye_q - ye_q) + (21'(py_q) <<< SUB_BITS)) - 21'(vy_q[0]);
    es    = step_q - FIRST_B;
    mul_a = '0;
    mul_b = '0;
    op_c  = '{tgt: T_NZ, ei: 2'd0, neg: 1'b0, shl: 1'b0};
    case (step_q)
      5'd0: begin mul_a = 34'(ex1); mul_b = 21'(ey2); end
      5'd1: begin mul_a = 34'(ey1); mul_b = 21'(ex2); op_c.neg = 1'b1; end
      5'd2: begin mul_a = 34'(ez2); mul_b = 21'(ey1); op_c.tgt = T_NX; end
      5'd3: begin mul_a = 34'(ez1); mul_b = 21'(ey2); op_c.tgt = T_NX; op_c.neg = 1'b1; end
      5'd4: begin mul_a = 34'(ez1); mul_b = 21'(ex2); op_c.tgt = T_NY; end
      5'd5: begin mul_a = 34'(ez2); mul_b = 21'(ex1); op_c.tgt = T_NY; op_c.neg = 1'b1; end
      5'd18: begin
        mul_a = $signed({8'd0, nx_q[25:0]}); mul_b = bx; op_c.tgt = T_N;
      end
      5'd19: begin
        mul_a = 34'($signed(nx_q[53:26])); mul_b = bx; op_c.tgt = T_N; op_c.shl = 1'b1;
      end
      5'd20: begin
        mul_a = $signed({8'd0, ny_q[25:0]}); mul_b = by; op_c.tgt = T_N;
      end
      5'd21: begin
        mul_a = 34'($signed(ny_q[53:26])); mul_b = by; op_c.tgt = T_N; op_c.shl = 1'b1;
      end
      5'd22: begin
        mul_a = $signed(34'(py_q)); mul_b = $signed(21'(w_c)); op_c.tgt = T_ROW;
      end
      default: begin
        op_c.tgt = T_E;
        op_c.ei  = es[3:2];
        case (es[1:0])
          2'd0: begin mul_a = 34'(dy[es[3:2]]); mul_b = 21'(vx_q[es[3:2]]); end
          2'd1: begin
            mul_a = 34'(dx[es[3:2]]); mul_b = 21'(vy_q[es[3:2]]); op_c.neg = 1'b1;
          end
          2'd2: begin mul_a = 34'(dx[es[3:2]]); mul_b = 21'(py_q) <<< SUB_BITS; end
          default: begin
            mul_a = 34'(dy[es[3:2]]); mul_b = 21'(xs_q) <<< SUB_BITS; op_c.neg = 1'b1;
          end
        endcase
      end
    endcase
    pw = NUM_W'(prod_q);
    if (op_q.shl) pw = pw <<< SHL;
    if (op_q.neg) pw = -pw;
  end

  // raster walk
  always_comb begin
    covered = (e_q[0] > 0) && (e_q[1] > 0) && (e_q[2] > 0);
    adv_x   = ({1'b0, px_q} + 1'b1) < {1'b0, xe_q};
    adv_y   = ({1'b0, py_q} + 1'b1) < {1'b0, ye_q};
    last    = !adv_x && !adv_y;
    do_adv  = (state_q == S_PIX && !covered) || (state_q == S_WB);
    idx     = rowbase_q + AW'(px_q);
    d_c     = -nz_q;
    num_c   = (n_q <<< 1) + NUM_W'(d_c);
    den_c   = DEN_W'({d_c, 1'b0});
    dsum    = 43'(z0_q) + 43'(qd_q);
    if (dsum > 43'sd2147483647)       dsat = 32'sh7FFFFFFF;
    else if (dsum < -43'sd2147483648) dsat = 32'sh80000000;
    else                              dsat = dsum[31:0];
    cnt_nx  = cnt_q + 21'(state_q == S_WB);
  end

  tmdr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_PIX && covered),
    .num_i   (num_c),
    .den_i   (den_c),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // depth stores
  always_comb begin
    mem_we = (state_q == S_CLEAR) || (state_q == S_WB);
    mem_re = (state_q == S_PIX && covered) || (state_q == S_RD);
    mem_wa = (state_q == S_CLEAR) ? clr_q : idx;
    mem_ra = (state_q == S_RD) ? addr_q[AW-1:0] : idx;
    if (state_q == S_CLEAR) begin
      min_wd = minclr_q;
      max_wd = maxclr_q;
    end else begin
      min_wd = (depth_q < min_rd_q) ? depth_q : min_rd_q;
      max_wd = (depth_q > max_rd_q) ? depth_q : max_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) min_mem[mem_wa] <= min_wd;
    if (mem_re) min_rd_q <= min_mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) max_mem[mem_wa] <= max_wd;
    if (mem_re) max_rd_q <= max_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      opv_q    <= 1'b0;
      clr_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
      cov_q    <= '0;
      rmin_q   <= '0;
      rmax_q   <= '0;
      width_q  <= 11'd640;
      height_q <= 11'd480;
      minclr_q <= 32'h7FFFFFFF;
      maxclr_q <= 32'h80000000;
    end else begin
      done_q <= 1'b0;
      opv_q  <= ((state_q == S_SETA) && (step_q < LAST_A)) ||
                ((state_q == S_SETB) && (step_q < LAST_B));
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          R_WIDTH:  width_q  <= cfg_data_i[10:0];
          R_HEIGHT: height_q <= cfg_data_i[10:0];
          R_MINCLR: minclr_q <= cfg_data_i;
          R_MAXCLR: maxclr_q <= cfg_data_i;
          default:  ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cov_q  <= '0;
            rmin_q <= '0;
            rmax_q <= '0;
            unique case (action_e'(action_i))
              A_DRAW: begin
                step_q  <= '0;
                state_q <= S_SETA;
              end
              A_CLEAR: begin
                clr_q   <= '0;
                state_q <= S_CLEAR;
              end
              A_READ: state_q <= S_RD;
              default: begin
                done_q   <= 1'b1;
                status_q <= ST_DONE;
              end
            endcase
          end
        end
        S_SETA: begin
          if (step_q == LAST_A) state_q <= S_SWAP;
          else step_q <= step_q + 1'b1;
        end
        S_SWAP: begin
          if (nz_q == '0) begin
            done_q   <= 1'b1;
            status_q <= ST_CULLED;
            state_q  <= S_IDLE;
          end else if (empty) begin
            done_q   <= 1'b1;
            status_q <= ST_CLIPPED;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          step_q  <= FIRST_B;
          state_q <= S_SETB;
        end
        S_SETB: begin
          if (step_q == LAST_B) state_q <= S_LOAD;
          else step_q <= step_q + 1'b1;
        end
        S_LOAD: state_q <= S_PIX;
        S_PIX: begin
          if (covered) state_q <= S_DIV;
          else if (last) begin
            done_q   <= 1'b1;
            status_q <= ST_DRAWN;
            cov_q    <= cnt_nx;
            state_q  <= S_IDLE;
          end
        end
        S_DIV: if (div_done) state_q <= S_DEP;
        S_DEP: state_q <= S_WB;
        S_WB: begin
          if (last) begin
            done_q   <= 1'b1;
            status_q <= ST_DRAWN;
            cov_q    <= cnt_nx;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_PIX;
          end
        end
        S_CLEAR: begin
          if (clr_q == AW'(STORE_N - 1)) begin
            done_q   <= 1'b1;
            status_q <= ST_DONE;
            state_q  <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_RD: state_q <= S_RDOUT;
        S_RDOUT: begin
          done_q   <= 1'b1;
          status_q <= ST_DONE;
          rmin_q   <= min_rd_q;
          rmax_q   <= max_rd_q;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    op_q   <= op_c;
    if (accept) begin
      vx_q[0] <= v0_x_i;
      vy_q[0] <= v0_y_i;
      vx_q[1] <= v1_x_i;
      vy_q[1] <= v1_y_i;
      vx_q[2] <= v2_x_i;
      vy_q[2] <= v2_y_i;
      z0_q    <= v0_z_i;
      z1_q    <= v1_z_i;
      z2_q    <= v2_z_i;
      addr_q  <= pixel_addr_i;
      nz_q    <= '0;
      nx_q    <= '0;
      ny_q    <= '0;
      cnt_q   <= '0;
    end
    if (opv_q) begin
      case (op_q.tgt)
        T_NZ:    nz_q <= nz_q + pw[39:0];
        T_NX:    nx_q <= nx_q + pw[53:0];
        T_NY:    ny_q <= ny_q + pw[53:0];
        T_E:     erow_q[op_q.ei] <= erow_q[op_q.ei] + pw[41:0];
        T_N:     nrow_q <= nrow_q + pw;
        default: rowbase_q <= rowbase_q + pw[AW-1:0];
      endcase
    end
    if (state_q == S_SWAP) begin
      // front facing: fix winding
      if (!nz_q[39]) begin
        vx_q[1] <= vx_q[2];
        vy_q[1] <= vy_q[2];
        vx_q[2] <= vx_q[1];
        vy_q[2] <= vy_q[1];
        nx_q    <= -nx_q;
        ny_q    <= -ny_q;
        nz_q    <= -nz_q;
      end
      xs_q <= xs_c[XW-1:0];
      xe_q <= xe_c[XW-1:0];
      px_q <= xs_c[XW-1:0];
      py_q <= ys_c[YW-1:0];
      ye_q <= ye_c[YW-1:0];
    end
    if (state_q == S_PREP) begin
      for (int i = 0; i < 3; i++) erow_q[i] <= 42'(tl[i]);
      nrow_q    <= '0;
      rowbase_q <= '0;
    end
    if (state_q == S_LOAD) begin
      for (int i = 0; i < 3; i++) e_q[i] <= erow_q[i];
      n_q <= nrow_q;
    end
    if (state_q == S_DIV && div_done) qd_q <= div_q;
    if (state_q == S_DEP) depth_q <= dsat;
    if (state_q == S_WB) cnt_q <= cnt_nx;
    if (do_adv) begin
      if (adv_x) begin
        px_q <= px_q + 1'b1;
        for (int i = 0; i < 3; i++) e_q[i] <= e_q[i] - (42'(dy[i]) <<< SUB_BITS);
        n_q <= n_q + (NUM_W'(nx_q) <<< SUB_BITS);
      end else if (adv_y) begin
        px_q <= xs_q;
        py_q <= py_q + 1'b1;
        for (int i = 0; i < 3; i++) begin
          erow_q[i] <= erow_q[i] + (42'(dx[i]) <<< SUB_BITS);
          e_q[i]    <= erow_q[i] + (42'(dx[i]) <<< SUB_BITS);
        end
        nrow_q    <= nrow_q + (NUM_W'(ny_q) <<< SUB_BITS);
        n_q       <= nrow_q + (NUM_W'(ny_q) <<< SUB_BITS);
        rowbase_q <= rowbase_q + AW'(w_c);
      end
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign covered_pixels_o = cov_q;
  assign read_min_o       = rmin_q;
  assign read_max_o       = rmax_q;

endmodule
`default_nettype wire
